// ----- hdl/pvm_pkg.sv -----
package pvm_pkg;

    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned POS_W     = 17;
    localparam int unsigned SLOT_W    = 2;
    localparam int unsigned LANES     = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [SAMPLE_W-1:0] SILENCE = 8'h80;

    localparam logic [LEN_W-1:0] PERIOD_LEN_RESET = 16'd512;
    localparam logic [LEN_W-1:0] BUFFER_END_RESET = 16'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_END = 2'd1;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_MIX   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RATE_NONE = 2'd0,
        RATE_SLOW = 2'd1,
        RATE_FAST = 2'd2
    } rate_t;

    typedef struct packed {
        logic             tick;
        logic             fast_mode;
        logic             rate_22;
        logic [LEN_W-1:0] sound_length;
        logic [LEN_W-1:0] period_len;
    } lane_ctrl_t;

    typedef struct packed {
        logic active;
        logic fast;
    } lane_stat_t;

endpackage

// ----- hdl/pvm_voice_lane.sv -----
module pvm_voice_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  pvm_pkg::lane_ctrl_t ctrl,
    input  logic               start,
    output logic               active_next,
    output pvm_pkg::lane_stat_t stat
);
    import pvm_pkg::*;

    logic             active_reg;
    logic             fast_reg;
    logic [LEN_W-1:0] len_reg;
    logic [POS_W-1:0] pos_reg;

    logic             fast_next;
    logic [LEN_W-1:0] len_next;
    logic [POS_W-1:0] pos_next;
    logic [LEN_W-1:0] step;
    logic [POS_W-1:0] pos_sum;

    always_comb
    begin
        step = ctrl.period_len;
        if (ctrl.fast_mode && !fast_reg)
        begin
            step = ctrl.period_len >> 1;
        end
        pos_sum = pos_reg + {1'b0, step};

        active_next = active_reg;
        fast_next   = fast_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        if (start)
        begin
            active_next = 1'b1;
            fast_next   = ctrl.rate_22;
            len_next    = ctrl.sound_length;
            pos_next    = '0;
        end
        else if (ctrl.tick && active_reg)
        begin
            pos_next = pos_sum;
            if (pos_sum >= {1'b0, len_reg})
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            fast_reg   <= 1'b0;
            len_reg    <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            fast_reg   <= fast_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
        end
    end

    assign stat.active = active_reg;
    assign stat.fast   = fast_reg;

endmodule

// ----- hdl/pvm_mix_merge.sv -----
module pvm_mix_merge #(
    parameter int unsigned VOICES = 4
) (
    input  logic [VOICES-1:0]                        active,
    input  logic [VOICES-1:0][pvm_pkg::SAMPLE_W-1:0] bytes,
    output logic [pvm_pkg::SAMPLE_W-1:0]             mixed
);
    import pvm_pkg::*;

    logic                first;
    logic [SAMPLE_W:0]   sum;

    always_comb
    begin
        first = 1'b1;
        mixed = SILENCE;
        sum   = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            sum = {1'b0, mixed} + {1'b0, bytes[v]};
            if (active[v])
            begin
                if (first)
                begin
                    mixed = bytes[v];
                    first = 1'b0;
                end
                else
                begin
                    mixed = sum[SAMPLE_W:1];
                end
            end
        end
    end

endmodule

// ----- hdl/pcm_voice_mixer_core.sv -----
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tuser kind, tdata start and mix fields
// m_*       out        m_tvalid / m_tready  tdata one result per request
// cfg_*     in         cfg_valid / cfg_ready register index and value
//
// Every request gives one result, registered and presented in the cycle after it is accepted;
// one request per cycle is sustained while m_tready stays high, set by the single output register.
// The input is ready whenever the output register is empty or is being drained.
// Reset clears all voices, the rate mode, pending switches and the buffer offset.
// Configuration is always ready and takes effect on the next request.
module pcm_voice_mixer_core #(
    parameter int unsigned VOICES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rate_22, sound_length, sample_v0, sample_v1, sample_v2, sample_v3
    input  logic [pvm_pkg::IN_DATA_W-1:0]       s_tdata,
    // kind
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mixed_sample, slot_index, slot_found, rate_change, mode_is_22,
    // write_offset, playing_mask
    output logic [pvm_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pvm_pkg::LEN_W-1:0]           cfg_data
);
    import pvm_pkg::*;

    logic [LEN_W-1:0] period_len_reg;
    logic [LEN_W-1:0] buffer_end_reg;
    logic             fast_mode_reg;
    logic             fast_mode_next;
    logic             want_fast_reg;
    logic             want_fast_next;
    logic             want_slow_reg;
    logic             want_slow_next;
    logic [LEN_W-1:0] buf_offset_reg;
    logic [LEN_W-1:0] buf_offset_next;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    logic        accept;
    kind_t       kind;
    logic        rate_22;
    logic [LEN_W-1:0] sound_length;
    logic [LEN_W:0]   offset_sum;
    rate_t       rate_change;
    logic        any_fast;

    lane_ctrl_t                     lane_ctrl;
    lane_stat_t [VOICES-1:0]        lane_stat;
    logic [VOICES-1:0]              lane_active;
    logic [VOICES-1:0]              lane_active_next;
    logic [VOICES-1:0]              lane_start;
    logic [VOICES-1:0][SAMPLE_W-1:0] lane_bytes;
    logic [SAMPLE_W-1:0]            mixed;
    logic [SAMPLE_W-1:0]            mixed_out;
    logic [SLOT_W-1:0]              slot_index;
    logic                           slot_found;
    logic [LANES-1:0]               playing_mask;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign kind         = kind_t'(s_tuser);
    assign rate_22      = s_tdata[0];
    assign sound_length = s_tdata[LEN_W:1];

    always_comb
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            lane_active[v] = lane_stat[v].active;
            if (v < LANES)
            begin
                lane_bytes[v] = s_tdata[LEN_W + 1 + v * SAMPLE_W +: SAMPLE_W];
            end
            else
            begin
                lane_bytes[v] = SILENCE;
            end
        end
    end

    // First free slot
    always_comb
    begin
        slot_found = 1'b0;
        slot_index = '0;
        lane_start = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (!lane_active[v] && !slot_found)
            begin
                slot_found    = 1'b1;
                slot_index    = SLOT_W'(v);
                lane_start[v] = accept && (kind == KIND_START);
            end
        end
    end

    always_comb
    begin
        any_fast = 1'b0;
        for (int v = 0; v < VOICES; v++)
        begin
            any_fast = any_fast || (lane_stat[v].active && lane_stat[v].fast);
        end
    end

    always_comb
    begin
        fast_mode_next  = fast_mode_reg;
        want_fast_next  = want_fast_reg;
        want_slow_next  = want_slow_reg;
        buf_offset_next = buf_offset_reg;
        rate_change     = RATE_NONE;
        offset_sum      = {1'b0, buf_offset_reg} + {1'b0, period_len_reg};

        if (kind == KIND_TICK)
        begin
            if (want_fast_reg)
            begin
                want_fast_next = 1'b0;
                want_slow_next = 1'b0;
                fast_mode_next = 1'b1;
                rate_change    = RATE_FAST;
            end
            else if (want_slow_reg)
            begin
                want_slow_next = 1'b0;
                fast_mode_next = 1'b0;
                rate_change    = RATE_SLOW;
            end
            if (offset_sum >= {1'b0, buffer_end_reg})
            begin
                buf_offset_next = '0;
            end
            else
            begin
                buf_offset_next = offset_sum[LEN_W-1:0];
            end
            if (fast_mode_next && !any_fast)
            begin
                want_slow_next = 1'b1;
            end
        end
        else if (kind == KIND_START)
        begin
            if (slot_found && rate_22 && !fast_mode_reg)
            begin
                want_fast_next = 1'b1;
            end
        end
    end

    assign lane_ctrl.tick         = accept && (kind == KIND_TICK);
    assign lane_ctrl.fast_mode    = fast_mode_next;
    assign lane_ctrl.rate_22      = rate_22;
    assign lane_ctrl.sound_length = sound_length;
    assign lane_ctrl.period_len   = period_len_reg;

    for (genvar g = 0; g < VOICES; g++)
    begin : g_lane
        pvm_voice_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .start       (lane_start[g]),
            .active_next (lane_active_next[g]),
            .stat        (lane_stat[g])
        );
    end

    pvm_mix_merge #(
        .VOICES (VOICES)
    ) u_merge (
        .active (lane_active),
        .bytes  (lane_bytes),
        .mixed  (mixed)
    );

    always_comb
    begin
        playing_mask = '0;
        for (int v = 0; v < LANES; v++)
        begin
            if (v < VOICES)
            begin
                playing_mask[v] = lane_active_next[v];
            end
        end
        mixed_out = (kind == KIND_MIX) ? mixed : SILENCE;
        m_tdata_next = {
            {(OUT_DATA_W - 34){1'b0}},
            playing_mask,
            buf_offset_next,
            fast_mode_next,
            rate_change,
            (kind == KIND_START) ? slot_found : 1'b0,
            (kind == KIND_START && slot_found) ? slot_index : {SLOT_W{1'b0}},
            mixed_out
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_len_reg <= PERIOD_LEN_RESET;
            buffer_end_reg <= BUFFER_END_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PERIOD_LEN)
            begin
                period_len_reg <= cfg_data;
            end
            else if (cfg_index == REG_BUFFER_END)
            begin
                buffer_end_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_mode_reg  <= 1'b0;
            want_fast_reg  <= 1'b0;
            want_slow_reg  <= 1'b0;
            buf_offset_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fast_mode_reg  <= fast_mode_next;
                want_fast_reg  <= want_fast_next;
                want_slow_reg  <= want_slow_next;
                buf_offset_reg <= buf_offset_next;
                m_tvalid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
